[hdl/stable_zorder_insertion_sort_core_macros.svh]
// ----------------------------------------------------------------------------
// Stable z-order insertion sort: assertion macros
// Shared property wrappers; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef STABLE_ZORDER_INSERTION_SORT_CORE_MACROS_SVH
`define STABLE_ZORDER_INSERTION_SORT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SZIS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SZIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/szis_pkg.sv]
// ----------------------------------------------------------------------------
// Stable z-order insertion sort: package
// Item types, sizes and controller states shared by all modules.
// ----------------------------------------------------------------------------
package szis_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [15:0]        item_id;
    logic signed [31:0] depth_key;
    logic               last_item;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        sorted_id;
    logic signed [31:0] sorted_key;
    logic               end_of_list;
    logic               overflow;
  } out_item_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } szis_state_t;

endpackage

[hdl/szis_in_queue.sv]
// ----------------------------------------------------------------------------
// Stable z-order insertion sort: input queue
// Front end: takes input beats and holds them until the sorter is ready.
// ----------------------------------------------------------------------------
`include "stable_zorder_insertion_sort_core_macros.svh"

module szis_in_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  szis_pkg::in_item_t in_item,
  output logic               q_valid,
  input  logic               q_pop,
  output szis_pkg::in_item_t q_item
);
  import szis_pkg::*;

  in_item_t           slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign full    = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = slot_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= in_item;
    end
  end

  `SZIS_ASSERT_NOW(a_q_occupancy, 1'b1, cnt_r <= Q_CNT_W'(Q_DEPTH), "queue over capacity")
  `SZIS_ASSERT_NOW(a_q_no_underrun, q_pop, cnt_r != '0, "pop from empty queue")
  `SZIS_ASSERT_NEXT(a_q_fill, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1, "lost beat")

endmodule

[hdl/szis_sort_chain.sv]
// ----------------------------------------------------------------------------
// Stable z-order insertion sort: sorting chain
// Back end: inserts each item into a sorted register chain while it has room, then
// shifts the chain out through a result register when the last item arrives.
// ----------------------------------------------------------------------------
`include "stable_zorder_insertion_sort_core_macros.svh"

module szis_sort_chain (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  szis_pkg::in_item_t  q_item,
  output logic                empty,
  input  logic                pop,
  output szis_pkg::out_item_t out_item
);
  import szis_pkg::*;

  logic signed [31:0] key_r [MAX_ITEMS];
  logic [15:0]        id_r  [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] gt;

  szis_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             drop_r, drop_nxt;
  logic             out_vld_r, out_vld_nxt;
  out_item_t        out_item_r;

  logic store_full, ins, emit, emit_last, out_taken;

  assign store_full = (cnt_r == CNT_W'(MAX_ITEMS));
  assign out_taken  = pop && out_vld_r;
  assign emit_last  = emit && (cnt_r == CNT_W'(1));
  assign empty      = !out_vld_r;
  assign out_item   = out_item_r;

  // A cell is "greater" when it is empty or holds a strictly larger key, so
  // equal keys stay ahead of the newcomer.
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      gt[i] = (CNT_W'(i) >= cnt_r) || (key_r[i] > q_item.depth_key);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (q_valid && q_item.last_item) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (emit_last) state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    ins   = 1'b0;
    emit  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        q_pop = q_valid;
        ins   = q_valid && !store_full;
      end
      ST_DRAIN: begin
        emit = !out_vld_r || pop;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (ins) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (emit) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    drop_nxt = drop_r;
    if (q_pop && store_full) begin
      drop_nxt = 1'b1;
    end else if (emit_last) begin
      drop_nxt = 1'b0;
    end
    out_vld_nxt = emit ? 1'b1 : (out_taken ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      drop_r    <= drop_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.sorted_id   <= id_r[0];
      out_item_r.sorted_key  <= key_r[0];
      out_item_r.end_of_list <= (cnt_r == CNT_W'(1));
      out_item_r.overflow    <= drop_r;
    end
  end

  // Each cell either keeps its entry, takes the new item, or takes its lower
  // neighbor on insert; on drain the chain moves one place toward cell zero.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic take_new;
    if (i == 0) begin : g_head
      assign take_new = gt[0];
    end else begin : g_body
      assign take_new = gt[i] && !gt[i-1];
    end

    always_ff @(posedge clk) begin
      if (ins && gt[i]) begin
        if (take_new) begin
          key_r[i] <= q_item.depth_key;
          id_r[i]  <= q_item.item_id;
        end else if (i > 0) begin
          key_r[i] <= key_r[(i > 0) ? i - 1 : 0];
          id_r[i]  <= id_r[(i > 0) ? i - 1 : 0];
        end
      end else if (emit && (i < MAX_ITEMS - 1)) begin
        key_r[i] <= key_r[(i < MAX_ITEMS - 1) ? i + 1 : i];
        id_r[i]  <= id_r[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
    end
  end

  `SZIS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_ITEMS), "item count over capacity")
  `SZIS_ASSERT_NOW(a_drain_nonempty, state_r == ST_DRAIN, cnt_r != '0, "drain with empty chain")
  `SZIS_ASSERT_NEXT(a_end_returns, emit_last,
    (state_r == ST_LOAD) && (cnt_r == '0) && !drop_r, "list end did not restart loading")
  `SZIS_ASSERT_NOW(a_head_sorted, cnt_r >= CNT_W'(2), key_r[0] <= key_r[1], "chain head unsorted")

endmodule

[hdl/stable_zorder_insertion_sort_core.sv]
// An input beat is written into the queue and then inserted into the chain; the first result of
// a list is loaded into the result register once the chain has entered drain after the last item.
// Throughput: one item per cycle while loading, set by the insert of the compare-and-shift chain;
// one result per cycle while draining and results are popped, and loading waits for the drain.
// Reset: rst_n is synchronous and active low; it empties the queue and the chain and clears
// the overflow mark. Stored keys and handles are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// Stable z-order insertion sort core
// Queue-style front end feeding a sorted register chain with a result register.
// ----------------------------------------------------------------------------
module stable_zorder_insertion_sort_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  szis_pkg::in_item_t  in_item,
  output logic                empty,
  input  logic                pop,
  output szis_pkg::out_item_t out_item
);
  import szis_pkg::*;

  logic     q_valid;
  logic     q_pop;
  in_item_t q_item;

  szis_in_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_item (in_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  szis_sort_chain u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

endmodule
